// ===== design/nlsc_pkg.sv =====
// nlsc_pkg: shared types, codes and parse step function for the nested-list checker
`timescale 1ns / 1ps

package nlsc_pkg;

   localparam int MAX_DEPTH_DEFAULT = 16;
   localparam int DEPTH_W = 5;

   localparam logic [7:0] CH_OPEN   = 8'h5B;  // [
   localparam logic [7:0] CH_CLOSE  = 8'h5D;  // ]
   localparam logic [7:0] CH_COMMA  = 8'h2C;  // ,
   localparam logic [7:0] CH_EQUALS = 8'h3D;  // =
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_Z   = 8'h7A;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_Z   = 8'h5A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef enum logic [2:0] {
      TK_NONE   = 3'd0,
      TK_EOF    = 3'd1,
      TK_COMMA  = 3'd2,
      TK_OPEN   = 3'd3,
      TK_CLOSE  = 3'd4,
      TK_EQUALS = 3'd5,
      TK_NAME   = 3'd6
   } tok_type;

   typedef enum logic [2:0] {
      PH_OUTER      = 3'd0,
      PH_ELEM       = 3'd1,
      PH_AFTER_NAME = 3'd2,
      PH_VALUE      = 3'd3,
      PH_AFTER_ELEM = 3'd4,
      PH_DONE       = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUN = 2'd0,
      ST_OK  = 2'd1,
      ST_ERR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_CHAR  = 3'd1,
      ERR_UNEXPECT  = 3'd2,
      ERR_OVERFLOW  = 3'd3,
      ERR_PREMATURE = 3'd4
   } err_type;

   typedef struct packed {
      phase_type          phase;
      logic [DEPTH_W-1:0] open_count;
      logic               name_open;
      status_type         outcome;
      err_type            fault;
   } parse_state_type;

   function automatic parse_state_type set_fault(parse_state_type s, err_type code);
      parse_state_type r;
      r = s;
      if (s.outcome == ST_RUN) begin
         r.outcome = ST_ERR;
         r.fault   = code;
      end
      return r;
   endfunction

   function automatic parse_state_type push_level(parse_state_type s,
                                                  logic [DEPTH_W-1:0] cap);
      parse_state_type r;
      r = s;
      if (s.open_count >= cap) begin
         r = set_fault(s, ERR_OVERFLOW);
      end else begin
         r.open_count = s.open_count + 1'b1;
         r.phase      = PH_ELEM;
      end
      return r;
   endfunction

   function automatic parse_state_type pop_level(parse_state_type s);
      parse_state_type r;
      r = s;
      r.open_count = s.open_count - 1'b1;
      if (r.open_count == '0) begin
         r.phase   = PH_DONE;
         r.outcome = ST_OK;
      end else begin
         r.phase = PH_AFTER_ELEM;
      end
      return r;
   endfunction

   // one grammar step for one token
   function automatic parse_state_type parse_tok(parse_state_type s, tok_type t,
                                                 logic [DEPTH_W-1:0] cap);
      parse_state_type r;
      r = s;
      if (s.outcome == ST_RUN) begin
         if (t == TK_EOF) begin
            r = set_fault(s, ERR_PREMATURE);
         end else begin
            unique case (s.phase)
               PH_OUTER: begin
                  if (t == TK_OPEN) r = push_level(s, cap);
                  else r = set_fault(s, ERR_UNEXPECT);
               end
               PH_ELEM: begin
                  if (t == TK_NAME) r.phase = PH_AFTER_NAME;
                  else if (t == TK_OPEN) r = push_level(s, cap);
                  else r = set_fault(s, ERR_UNEXPECT);
               end
               PH_AFTER_NAME: begin
                  if (t == TK_EQUALS) r.phase = PH_VALUE;
                  else if (t == TK_COMMA) r.phase = PH_ELEM;
                  else if (t == TK_CLOSE) r = pop_level(s);
                  else r = set_fault(s, ERR_UNEXPECT);
               end
               PH_VALUE: begin
                  if (t == TK_NAME) r.phase = PH_AFTER_ELEM;
                  else r = set_fault(s, ERR_UNEXPECT);
               end
               PH_AFTER_ELEM: begin
                  if (t == TK_COMMA) r.phase = PH_ELEM;
                  else if (t == TK_CLOSE) r = pop_level(s);
                  else r = set_fault(s, ERR_UNEXPECT);
               end
               default: begin
                  r = s;
               end
            endcase
         end
      end
      return r;
   endfunction

endpackage

// ===== design/nlsc_step.sv =====
// nlsc_step: lexer and parse update for one character
`timescale 1ns / 1ps

module nlsc_step
   import nlsc_pkg::*;
#(
   parameter int MAX_DEPTH = MAX_DEPTH_DEFAULT
) (
   input  parse_state_type cur_state,
   input  logic [7:0]      ch,
   input  logic            end_mark,
   output parse_state_type next_state,
   output logic            name_done,
   output tok_type         token_kind
);

   localparam int CAP_INT = (MAX_DEPTH < 31) ? MAX_DEPTH : 31;
   localparam logic [DEPTH_W-1:0] DEPTH_CAP = CAP_INT[DEPTH_W-1:0];

   logic            is_letter;
   logic            is_blank;
   tok_type         kind;
   logic            bad_char;
   parse_state_type after_name;

   assign is_letter = ((ch >= CH_LC_A) && (ch <= CH_LC_Z)) ||
                      ((ch >= CH_UC_A) && (ch <= CH_UC_Z));
   assign is_blank  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
                      (ch == CH_CR);

   always_comb begin
      kind     = TK_NONE;
      bad_char = 1'b0;
      if (end_mark) begin
         kind = TK_EOF;
      end else begin
         case (ch)
            CH_COMMA:  kind = TK_COMMA;
            CH_OPEN:   kind = TK_OPEN;
            CH_CLOSE:  kind = TK_CLOSE;
            CH_EQUALS: kind = TK_EQUALS;
            default:   bad_char = !is_blank;
         endcase
      end
   end

   always_comb begin
      next_state = cur_state;
      name_done  = 1'b0;
      token_kind = TK_NONE;
      after_name = cur_state;
      if (cur_state.outcome == ST_RUN) begin
         if (!end_mark && is_letter) begin
            next_state.name_open = 1'b1;
         end else begin
            // a pending name is checked before the delimiter's own token
            if (cur_state.name_open) begin
               name_done  = 1'b1;
               after_name = parse_tok(cur_state, TK_NAME, DEPTH_CAP);
               after_name.name_open = 1'b0;
            end
            token_kind = kind;
            if (bad_char) begin
               next_state = set_fault(after_name, ERR_BAD_CHAR);
            end else if (kind != TK_NONE) begin
               next_state = parse_tok(after_name, kind, DEPTH_CAP);
            end else begin
               next_state = after_name;
            end
         end
      end
   end

endmodule

// ===== design/nested_list_syntax_checker_top.sv =====
// nested_list_syntax_checker_top: streaming nested-list syntax checker
`timescale 1ns / 1ps
//
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_ready   req_ch[7:0], req_end_mark
//  rsp_      out        rsp_valid/rsp_ready   rsp_name_done, rsp_token_kind, rsp_status,
//                                             rsp_error_code, rsp_nest_depth
//
//  one request per cycle while rsp_ready is high; each request gives one response,
//  held first in the input register, then in the response register.
//  the parse state updates as a request moves from input to response register.
//  synchronous reset clears both registers' valid and the parse state.
//  when rsp_ready is low the response holds and the input register holds one
//  more request before req_ready drops.

module nested_list_syntax_checker_top
   import nlsc_pkg::*;
#(
   parameter int MAX_DEPTH = MAX_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_ch,
   input  logic         req_end_mark,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_name_done,
   output logic [2:0]   rsp_token_kind,
   output logic [1:0]   rsp_status,
   output logic [2:0]   rsp_error_code,
   output logic [4:0]   rsp_nest_depth
);

   logic            in_valid_ff;
   logic [7:0]      in_ch_ff;
   logic            in_end_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic            rsp_valid_ff;
   logic            rsp_done_ff;
   tok_type         rsp_kind_ff;
   logic            done_in;
   tok_type         kind_in;
   logic            out_open;
   logic            advance;

   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_open;
   assign req_ready = !in_valid_ff || out_open;

   nlsc_step #(
      .MAX_DEPTH(MAX_DEPTH)
   ) u_step (
      .cur_state (state_ff),
      .ch        (in_ch_ff),
      .end_mark  (in_end_ff),
      .next_state(state_in),
      .name_done (done_in),
      .token_kind(kind_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ch_ff  <= req_ch;
         in_end_ff <= req_end_mark;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_OUTER;
         state_ff.open_count <= '0;
         state_ff.name_open  <= 1'b0;
         state_ff.outcome    <= ST_RUN;
         state_ff.fault      <= ERR_NONE;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (out_open) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_done_ff <= done_in;
         rsp_kind_ff <= kind_in;
      end
   end

   // status, error and depth mirror the committed parse state
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_name_done  = rsp_done_ff;
   assign rsp_token_kind = rsp_kind_ff;
   assign rsp_status     = state_ff.outcome;
   assign rsp_error_code = state_ff.fault;
   assign rsp_nest_depth = state_ff.open_count;

endmodule
